// ===== rtl/core/vna_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vna_pkg
// shared constants and types of the vertex normal accumulator
// ----------------------------------------------------------------------------
package vna_pkg;

  localparam int unsigned IndexW       = 12;
  localparam int unsigned CoordW       = 24;
  localparam int unsigned NormW        = 16;
  localparam int unsigned DefMaxVerts  = 4096;
  localparam int unsigned DefSumW      = 24;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_TRI   = 2'd1,
    KIND_READ  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

endpackage
`default_nettype wire

// ===== rtl/core/vertex_normal_accumulator_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vertex_normal_accumulator_top
// mesh vertex-normal engine: stores vertices, adds unit face normals of
// triangles to corner sums, returns normalized vertex normals
// ----------------------------------------------------------------------------
// A request is taken only while the engine is idle. A vertex write stores the
// vertex and clears its sum without leaving idle. Triangles and reads share
// the unit-vector engine (a triangle whose cross product is zero skips it),
// which runs a shift search, squares and a square root, and a bit-serial
// divide per component; the vertex and sum memories (one write and one read
// port each) are visited one corner at a time. The result register holds a
// read's answer while the next request is taken.
module vertex_normal_accumulator_top #(
  parameter int unsigned MAX_VERTICES = vna_pkg::DefMaxVerts,
  parameter int unsigned SUM_WIDTH    = vna_pkg::DefSumW
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [1:0]                        kind_i,
  input  logic [vna_pkg::IndexW-1:0]        index_a_i,
  input  logic [vna_pkg::IndexW-1:0]        index_b_i,
  input  logic [vna_pkg::IndexW-1:0]        index_c_i,
  input  logic signed [vna_pkg::CoordW-1:0] coord_x_i,
  input  logic signed [vna_pkg::CoordW-1:0] coord_y_i,
  input  logic signed [vna_pkg::CoordW-1:0] coord_z_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [vna_pkg::IndexW-1:0]        read_index_o,
  output logic signed [vna_pkg::NormW-1:0]  normal_x_o,
  output logic signed [vna_pkg::NormW-1:0]  normal_y_o,
  output logic signed [vna_pkg::NormW-1:0]  normal_z_o
);
  import vna_pkg::*;

  localparam int unsigned AddrW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int unsigned VertW = 3 * CoordW;
  localparam int unsigned SumsW = 3 * SUM_WIDTH;

  typedef enum logic [11:0] {
    S_IDLE  = 12'b0000_0000_0001,
    S_TRD   = 12'b0000_0000_0010,
    S_TCAP  = 12'b0000_0000_0100,
    S_CROSS = 12'b0000_0000_1000,
    S_CSUB  = 12'b0000_0001_0000,
    S_UWAIT = 12'b0000_0010_0000,
    S_ARD   = 12'b0000_0100_0000,
    S_AWR   = 12'b0000_1000_0000,
    S_RRD   = 12'b0001_0000_0000,
    S_RWAIT = 12'b0010_0000_0000,
    S_OUT   = 12'b0100_0000_0000,
    S_ZOUT  = 12'b1000_0000_0000
  } state_e;

  logic [VertW-1:0] vmem [MAX_VERTICES];
  logic [SumsW-1:0] smem [MAX_VERTICES];

  state_e            state_q, state_d;
  logic [AddrW-1:0]  idx_q [3];
  logic [AddrW-1:0]  idx_d [3];
  logic [IndexW-1:0] ridx_q, ridx_d;
  logic [1:0]        cnt_q, cnt_d;
  logic [1:0]        cap_q, cap_d;
  logic signed [CoordW:0]   d1_q [3];
  logic signed [CoordW:0]   d1_d [3];
  logic signed [CoordW:0]   d2_q [3];
  logic signed [CoordW:0]   d2_d [3];
  logic signed [CoordW-1:0] va_q [3];
  logic signed [CoordW-1:0] va_d [3];
  logic signed [51:0] pa_q, pa_d, pb_q, pb_d;
  logic signed [51:0] cr_q [3];
  logic signed [51:0] cr_d [3];
  logic signed [NormW-1:0] fn_q [3];
  logic signed [NormW-1:0] fn_d [3];
  logic        ov_q, ov_d;
  logic [VertW-1:0] vrd_q;
  logic [SumsW-1:0] srd_q;
  logic              vwe, swe;
  logic [AddrW-1:0]  vwa, vra, swa, sra;
  logic [VertW-1:0]  vwd;
  logic [SumsW-1:0]  swd;
  logic              ustart;
  logic signed [51:0] ux, uy, uz;
  logic              udone;
  logic signed [NormW-1:0] unx, uny, unz;
  logic signed [CoordW-1:0] rv [3];
  logic signed [SUM_WIDTH-1:0] rs [3];
  logic signed [SUM_WIDTH:0] sadd [3];
  logic signed [SUM_WIDTH-1:0] ssat [3];
  logic signed [2*CoordW+1:0] prod_a, prod_b;
  logic [1:0] mi;
  logic [1:0] mj;
  logic in_acc;
  logic range_ok;

  localparam logic signed [SUM_WIDTH:0] SatHi = (SUM_WIDTH+1)'((64'sd1 <<< (SUM_WIDTH-1)) - 1);
  localparam logic signed [SUM_WIDTH:0] SatLo = (SUM_WIDTH+1)'(-(64'sd1 <<< (SUM_WIDTH-1)));

  always_ff @(posedge clk_i) begin
    if (vwe) vmem[vwa] <= vwd;
    vrd_q <= vmem[vra];
  end

  always_ff @(posedge clk_i) begin
    if (swe) smem[swa] <= swd;
    srd_q <= smem[sra];
  end

  vna_unit u_unit (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ustart),
    .vx_i    (ux),
    .vy_i    (uy),
    .vz_i    (uz),
    .done_o  (udone),
    .nx_o    (unx),
    .ny_o    (uny),
    .nz_o    (unz)
  );

  assign in_acc   = in_valid_i && !in_stall_o;
  assign range_ok = ({20'd0, index_a_i} < 32'(MAX_VERTICES))
                 && ({20'd0, index_b_i} < 32'(MAX_VERTICES))
                 && ({20'd0, index_c_i} < 32'(MAX_VERTICES));

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rv[i] = vrd_q[i*CoordW +: CoordW];
      rs[i] = srd_q[i*SUM_WIDTH +: SUM_WIDTH];
      sadd[i] = (SUM_WIDTH+1)'(rs[i]) + (SUM_WIDTH+1)'(fn_q[i]);
      if (sadd[i] > SatHi)      ssat[i] = SatHi[SUM_WIDTH-1:0];
      else if (sadd[i] < SatLo) ssat[i] = SatLo[SUM_WIDTH-1:0];
      else                      ssat[i] = sadd[i][SUM_WIDTH-1:0];
    end
    // cross product term indices for component cnt
    unique case (cnt_q)
      2'd0:    begin mi = 2'd1; mj = 2'd2; end
      2'd1:    begin mi = 2'd2; mj = 2'd0; end
      default: begin mi = 2'd0; mj = 2'd1; end
    endcase
    prod_a = d1_q[mi] * d2_q[mj];
    prod_b = d1_q[mj] * d2_q[mi];
  end

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    ridx_d  = ridx_q;
    cnt_d   = cnt_q;
    cap_d   = cap_q;
    d1_d    = d1_q;
    d2_d    = d2_q;
    va_d    = va_q;
    pa_d    = pa_q;
    pb_d    = pb_q;
    cr_d    = cr_q;
    fn_d    = fn_q;
    ov_d    = ov_q;
    vwe = 1'b0; vwa = idx_q[0]; vwd = '0;
    swe = 1'b0; swa = idx_q[0]; swd = '0;
    vra = idx_q[0]; sra = idx_q[0];
    ustart = 1'b0;
    ux = cr_q[0]; uy = cr_q[1]; uz = cr_q[2];
    if (ov_q && !out_stall_i) ov_d = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          idx_d[0] = AddrW'(index_a_i);
          idx_d[1] = AddrW'(index_b_i);
          idx_d[2] = AddrW'(index_c_i);
          ridx_d   = index_a_i;
          unique case (kind_e'(kind_i))
            KIND_WRITE: begin
              if (range_ok || ({20'd0, index_a_i} < 32'(MAX_VERTICES))) begin
                vwe = 1'b1; vwa = AddrW'(index_a_i);
                vwd = {coord_z_i, coord_y_i, coord_x_i};
                swe = 1'b1; swa = AddrW'(index_a_i);
              end
            end
            KIND_TRI: begin
              if (range_ok) begin
                cnt_d = 2'd0; cap_d = 2'd0;
                state_d = S_TRD;
              end
            end
            KIND_READ: begin
              if ({20'd0, index_a_i} < 32'(MAX_VERTICES)) state_d = S_RRD;
              else state_d = S_ZOUT;
            end
            default: ;
          endcase
        end
      end
      S_TRD: begin
        vra = idx_q[cnt_q];
        state_d = S_TCAP;
      end
      S_TCAP: begin
        for (int i = 0; i < 3; i++) begin
          if (cap_q == 2'd0) va_d[i] = rv[i];
          else if (cap_q == 2'd1) d1_d[i] = (CoordW+1)'(rv[i]) - (CoordW+1)'(va_q[i]);
          else d2_d[i] = (CoordW+1)'(rv[i]) - (CoordW+1)'(va_q[i]);
        end
        if (cap_q == 2'd2) begin
          cnt_d = 2'd0;
          state_d = S_CROSS;
        end else begin
          cap_d = cap_q + 2'd1;
          cnt_d = cnt_q + 2'd1;
          state_d = S_TRD;
        end
      end
      S_CROSS: begin
        pa_d = 52'(prod_a);
        pb_d = 52'(prod_b);
        state_d = S_CSUB;
      end
      S_CSUB: begin
        cr_d[cnt_q] = pa_q - pb_q;
        if (cnt_q == 2'd2) begin
          if ((cr_q[0] == '0) && (cr_q[1] == '0) && ((pa_q - pb_q) == '0)) begin
            state_d = S_IDLE;
          end else begin
            state_d = S_UWAIT;
          end
          ustart = 1'b0;
        end else begin
          cnt_d = cnt_q + 2'd1;
          state_d = S_CROSS;
        end
      end
      S_UWAIT: begin
        ustart = 1'b1;
        if (udone) begin
          fn_d[0] = unx; fn_d[1] = uny; fn_d[2] = unz;
          cnt_d = 2'd0;
          state_d = S_ARD;
        end
      end
      S_ARD: begin
        sra = idx_q[cnt_q];
        state_d = S_AWR;
      end
      S_AWR: begin
        swe = 1'b1;
        swa = idx_q[cnt_q];
        swd = {ssat[2], ssat[1], ssat[0]};
        if (cnt_q == 2'd2) begin
          state_d = S_IDLE;
        end else begin
          cnt_d = cnt_q + 2'd1;
          state_d = S_ARD;
        end
      end
      S_RRD: begin
        sra = idx_q[0];
        cap_d = 2'd0;
        state_d = S_RWAIT;
      end
      S_RWAIT: begin
        if (cap_q == 2'd0) begin
          cr_d[0] = 52'(rs[0]);
          cr_d[1] = 52'(rs[1]);
          cr_d[2] = 52'(rs[2]);
          cap_d = 2'd1;
        end else begin
          ustart = 1'b1;
          if (udone) begin
            fn_d[0] = unx; fn_d[1] = uny; fn_d[2] = unz;
            state_d = S_OUT;
          end
        end
      end
      S_ZOUT: begin
        for (int i = 0; i < 3; i++) fn_d[i] = '0;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!ov_q || !out_stall_i) begin
          ov_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // unit start is a level; the unit latches on its idle state only once
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

  logic [IndexW-1:0]       oidx_q;
  logic signed [NormW-1:0] on_q [3];

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    ridx_q <= ridx_d;
    cnt_q  <= cnt_d;
    cap_q  <= cap_d;
    d1_q   <= d1_d;
    d2_q   <= d2_d;
    va_q   <= va_d;
    pa_q   <= pa_d;
    pb_q   <= pb_d;
    cr_q   <= cr_d;
    fn_q   <= fn_d;
    if (state_q == S_OUT && (!ov_q || !out_stall_i)) begin
      oidx_q <= ridx_q;
      on_q   <= fn_q;
    end
  end

  assign in_stall_o   = (state_q != S_IDLE);
  assign out_valid_o  = ov_q;
  assign read_index_o = oidx_q;
  assign normal_x_o   = on_q[0];
  assign normal_y_o   = on_q[1];
  assign normal_z_o   = on_q[2];

endmodule
`default_nettype wire

// ===== rtl/core/vna_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vna_unit
// unit-vector engine: scales a vector, takes an iterative square root and
// divides each component by the root, one bit per cycle, into q2.14
// ----------------------------------------------------------------------------
module vna_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic signed [51:0]          vx_i,
  input  logic signed [51:0]          vy_i,
  input  logic signed [51:0]          vz_i,
  output logic                        done_o,
  output logic signed [vna_pkg::NormW-1:0] nx_o,
  output logic signed [vna_pkg::NormW-1:0] ny_o,
  output logic signed [vna_pkg::NormW-1:0] nz_o
);
  import vna_pkg::*;

  typedef enum logic [7:0] {
    U_IDLE = 8'b0000_0001,
    U_NORM = 8'b0000_0010,
    U_SQ   = 8'b0000_0100,
    U_ROOT = 8'b0000_1000,
    U_DIV  = 8'b0001_0000,
    U_FIN  = 8'b0010_0000,
    U_DONE = 8'b0100_0000,
    U_ZERO = 8'b1000_0000
  } ustate_e;

  ustate_e     state_q, state_d;
  logic [51:0] mag_q [3];
  logic [51:0] mag_d [3];
  logic [2:0]  neg_q, neg_d;
  logic [63:0] sq_q, sq_d;
  logic [63:0] res_q, res_d;
  logic [63:0] bit_q, bit_d;
  logic [1:0]  comp_q, comp_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [47:0] num_q, num_d;
  logic [32:0] drem_q, drem_d;
  logic [16:0] quo_q, quo_d;
  logic [15:0] out_q [3];
  logic [15:0] out_d [3];

  logic [51:0] m_max;
  logic [51:0] m_sel;
  logic [51:0] m_nxt;
  logic [59:0] sq_term;
  logic [63:0] trial;
  logic [32:0] dsh;
  logic [32:0] twor;
  logic [16:0] qfin;

  always_comb begin
    m_max = (mag_q[0] > mag_q[1]) ? mag_q[0] : mag_q[1];
    if (mag_q[2] > m_max) m_max = mag_q[2];
    unique case (comp_q)
      2'd0:    m_sel = mag_q[0];
      2'd1:    m_sel = mag_q[1];
      default: m_sel = mag_q[2];
    endcase
    // component that the next divide works on
    unique case (comp_q)
      2'd0:    m_nxt = mag_q[1];
      2'd1:    m_nxt = mag_q[2];
      default: m_nxt = mag_q[0];
    endcase
    sq_term = m_sel[29:0] * m_sel[29:0];
    trial   = res_q + bit_q;
    twor    = {res_q[31:0], 1'b0};
    dsh     = {drem_q[31:0], num_q[47]};
    qfin    = (quo_q > 17'd16384) ? 17'd16384 : quo_q;
  end

  always_comb begin
    state_d = state_q;
    mag_d   = mag_q;
    neg_d   = neg_q;
    sq_d    = sq_q;
    res_d   = res_q;
    bit_d   = bit_q;
    comp_d  = comp_q;
    cnt_d   = cnt_q;
    num_d   = num_q;
    drem_d  = drem_q;
    quo_d   = quo_q;
    out_d   = out_q;
    unique case (state_q)
      U_IDLE: begin
        if (start_i) begin
          neg_d    = {vz_i[51], vy_i[51], vx_i[51]};
          mag_d[0] = vx_i[51] ? 52'(-vx_i) : 52'(vx_i);
          mag_d[1] = vy_i[51] ? 52'(-vy_i) : 52'(vy_i);
          mag_d[2] = vz_i[51] ? 52'(-vz_i) : 52'(vz_i);
          state_d  = U_NORM;
        end
      end
      U_NORM: begin
        // one shift step per cycle
        if (m_max == '0) begin
          state_d = U_ZERO;
        end else if (m_max >= (52'd1 << 30)) begin
          for (int i = 0; i < 3; i++) mag_d[i] = mag_q[i] >> 1;
        end else if (m_max < (52'd1 << 29)) begin
          for (int i = 0; i < 3; i++) mag_d[i] = mag_q[i] << 1;
        end else begin
          sq_d    = '0;
          comp_d  = 2'd0;
          state_d = U_SQ;
        end
      end
      U_SQ: begin
        sq_d = sq_q + {4'd0, sq_term};
        if (comp_q == 2'd2) begin
          res_d   = '0;
          bit_d   = 64'd1 << 62;
          state_d = U_ROOT;
        end
        comp_d = comp_q + 2'd1;
      end
      U_ROOT: begin
        if (bit_q == '0) begin
          comp_d  = 2'd0;
          state_d = U_DIV;
          cnt_d   = 6'd48;
          num_d   = {3'd0, m_nxt[29:0], 15'd0} + {16'd0, res_q[31:0]};
          drem_d  = '0;
          quo_d   = '0;
        end else begin
          if (sq_q >= trial) begin
            sq_d  = sq_q - trial;
            res_d = (res_q >> 1) + bit_q;
          end else begin
            res_d = res_q >> 1;
          end
          bit_d = bit_q >> 2;
        end
      end
      U_DIV: begin
        // restoring division, one quotient bit per cycle
        num_d = num_q << 1;
        if (dsh >= twor) begin
          drem_d = dsh - twor;
          quo_d  = {quo_q[15:0], 1'b1};
        end else begin
          drem_d = dsh;
          quo_d  = {quo_q[15:0], 1'b0};
        end
        cnt_d = cnt_q - 6'd1;
        if (cnt_q == 6'd1) state_d = U_FIN;
      end
      U_FIN: begin
        out_d[comp_q] = neg_q[comp_q] ? 16'(-{1'b0, qfin}) : qfin[15:0];
        if (comp_q == 2'd2) begin
          state_d = U_DONE;
        end else begin
          comp_d  = comp_q + 2'd1;
          cnt_d   = 6'd48;
          num_d   = {3'd0, m_nxt[29:0], 15'd0} + {16'd0, res_q[31:0]};
          drem_d  = '0;
          quo_d   = '0;
          state_d = U_DIV;
        end
      end
      U_ZERO: begin
        for (int i = 0; i < 3; i++) out_d[i] = '0;
        state_d = U_DONE;
      end
      U_DONE: state_d = U_IDLE;
      default: state_d = U_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= U_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    neg_q  <= neg_d;
    sq_q   <= sq_d;
    res_q  <= res_d;
    bit_q  <= bit_d;
    comp_q <= comp_d;
    cnt_q  <= cnt_d;
    num_q  <= num_d;
    drem_q <= drem_d;
    quo_q  <= quo_d;
    out_q  <= out_d;
  end

  assign done_o = (state_q == U_DONE);
  assign nx_o   = out_q[0];
  assign ny_o   = out_q[1];
  assign nz_o   = out_q[2];

endmodule
`default_nettype wire

// ===== bench/tb_vertex_normal_accumulator_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_vertex_normal_accumulator_top
// self-checking bench: drives vertex writes, triangles and normal reads with
// random gaps and stalls, predicts each read normal in integer arithmetic and
// compares it field by field with what the engine returns
// ----------------------------------------------------------------------------
module tb_vertex_normal_accumulator_top;
  import vna_pkg::*;

  localparam int unsigned NumVerts = DefMaxVerts;
  localparam longint SumHi = (64'sd1 <<< (DefSumW - 1)) - 1;
  localparam longint SumLo = -SumHi - 1;
  localparam int unsigned IdleLimit = 20000;

  typedef struct {
    logic [IndexW-1:0]       idx;
    logic signed [NormW-1:0] nx;
    logic signed [NormW-1:0] ny;
    logic signed [NormW-1:0] nz;
  } normal_rd_t;

  class normal_scoreboard;
    longint     vtx[NumVerts][3];
    longint     sums[NumVerts][3];
    normal_rd_t pending_reads[$];
    int         errors;

    function new();
      errors = 0;
      foreach (vtx[i, j]) begin
        vtx[i][j]  = 0;
        sums[i][j] = 0;
      end
    endfunction

    task report(input string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    function longint unsigned int_sqrt(input longint unsigned x);
      longint unsigned res, bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv >>= 2;
      while (bitv != 0) begin
        if (x >= res + bitv) begin
          x   = x - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res >>= 1;
        end
        bitv >>= 2;
      end
      return res;
    endfunction

    function void unit_normal(input longint v[3], output longint o[3]);
      longint unsigned mag[3];
      longint unsigned m, sq, r, q;
      m = 0;
      for (int i = 0; i < 3; i++) begin
        mag[i] = (v[i] < 0) ? longint'(-v[i]) : longint'(v[i]);
        if (mag[i] > m) m = mag[i];
      end
      if (m == 0) begin
        o[0] = 0; o[1] = 0; o[2] = 0;
        return;
      end
      while (m >= (64'd1 << 30)) begin
        m >>= 1;
        for (int i = 0; i < 3; i++) mag[i] >>= 1;
      end
      while (m < (64'd1 << 29)) begin
        m <<= 1;
        for (int i = 0; i < 3; i++) mag[i] <<= 1;
      end
      sq = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
      r  = int_sqrt(sq);
      for (int i = 0; i < 3; i++) begin
        q = ((mag[i] << 15) + r) / (2 * r);
        if (q > 16384) q = 16384;
        o[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
      end
    endfunction

    function longint sat_sum(input longint a, input longint b);
      longint s;
      s = a + b;
      if (s > SumHi) s = SumHi;
      if (s < SumLo) s = SumLo;
      return s;
    endfunction

    function void note_request(input kind_e kind, input logic [IndexW-1:0] ia,
                               input logic [IndexW-1:0] ib, input logic [IndexW-1:0] ic,
                               input logic signed [CoordW-1:0] cx,
                               input logic signed [CoordW-1:0] cy,
                               input logic signed [CoordW-1:0] cz);
      longint d1[3], d2[3], cr[3], n[3];
      normal_rd_t rd;
      case (kind)
        KIND_WRITE: begin
          vtx[ia][0] = cx; vtx[ia][1] = cy; vtx[ia][2] = cz;
          for (int i = 0; i < 3; i++) sums[ia][i] = 0;
        end
        KIND_TRI: begin
          for (int i = 0; i < 3; i++) begin
            d1[i] = vtx[ib][i] - vtx[ia][i];
            d2[i] = vtx[ic][i] - vtx[ia][i];
          end
          cr[0] = d1[1] * d2[2] - d1[2] * d2[1];
          cr[1] = d1[2] * d2[0] - d1[0] * d2[2];
          cr[2] = d1[0] * d2[1] - d1[1] * d2[0];
          if (cr[0] != 0 || cr[1] != 0 || cr[2] != 0) begin
            unit_normal(cr, n);
            for (int i = 0; i < 3; i++) begin
              sums[ia][i] = sat_sum(sums[ia][i], n[i]);
              sums[ib][i] = sat_sum(sums[ib][i], n[i]);
              sums[ic][i] = sat_sum(sums[ic][i], n[i]);
            end
          end
        end
        KIND_READ: begin
          unit_normal(sums[ia], n);
          rd.idx = ia;
          rd.nx  = n[0][NormW-1:0];
          rd.ny  = n[1][NormW-1:0];
          rd.nz  = n[2][NormW-1:0];
          pending_reads.push_back(rd);
        end
        default: ;
      endcase
    endfunction

    task check_result(input logic [IndexW-1:0] idx, input logic signed [NormW-1:0] nx,
                      input logic signed [NormW-1:0] ny, input logic signed [NormW-1:0] nz);
      normal_rd_t rd;
      if (pending_reads.size() == 0) begin
        report($sformatf("unexpected result index %0d", idx));
        return;
      end
      rd = pending_reads.pop_front();
      if (idx !== rd.idx)
        report($sformatf("read_index got %0d want %0d", idx, rd.idx));
      if (nx !== rd.nx)
        report($sformatf("normal_x idx %0d got %0d want %0d", rd.idx, nx, rd.nx));
      if (ny !== rd.ny)
        report($sformatf("normal_y idx %0d got %0d want %0d", rd.idx, ny, rd.ny));
      if (nz !== rd.nz)
        report($sformatf("normal_z idx %0d got %0d want %0d", rd.idx, nz, rd.nz));
    endtask
  endclass

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  logic [1:0]               kind_i = KIND_NONE;
  logic [IndexW-1:0]        index_a_i = '0;
  logic [IndexW-1:0]        index_b_i = '0;
  logic [IndexW-1:0]        index_c_i = '0;
  logic signed [CoordW-1:0] coord_x_i = '0;
  logic signed [CoordW-1:0] coord_y_i = '0;
  logic signed [CoordW-1:0] coord_z_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic [IndexW-1:0]        read_index_o;
  logic signed [NormW-1:0]  normal_x_o;
  logic signed [NormW-1:0]  normal_y_o;
  logic signed [NormW-1:0]  normal_z_o;

  vertex_normal_accumulator_top dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .kind_i,
    .index_a_i, .index_b_i, .index_c_i, .coord_x_i, .coord_y_i, .coord_z_i,
    .out_valid_o, .out_stall_i, .read_index_o, .normal_x_o, .normal_y_o, .normal_z_o
  );

  normal_scoreboard sb = new();
  int unsigned      idle_cycles = 0;
  int unsigned      accepted_reqs = 0;
  logic [IndexW-1:0] written_idx[$];
  bit               is_written[NumVerts];

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      sb.note_request(kind_e'(kind_i), index_a_i, index_b_i, index_c_i,
                      coord_x_i, coord_y_i, coord_z_i);
      accepted_reqs++;
    end
    if (out_valid_o && !out_stall_i)
      sb.check_result(read_index_o, normal_x_o, normal_y_o, normal_z_o);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("tb_vertex_normal_accumulator_top: errors");
      $finish;
    end
  end

  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 9) == 0) return $urandom_range(20, 80);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  // receiver: random stalls, plus one long hold-off once traffic is going
  initial begin
    int unsigned len;
    bit held;
    held = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!held && accepted_reqs > 40) begin
        held = 1'b1;
        out_stall_i <= 1'b1;
        repeat (3000) @(posedge clk_i);
      end
      len = pick_gap();
      out_stall_i <= (len > 0);
      repeat (len > 0 ? len : $urandom_range(1, 10)) @(posedge clk_i);
    end
  end

  task automatic send_request(input kind_e kind, input logic [IndexW-1:0] ia,
                              input logic [IndexW-1:0] ib, input logic [IndexW-1:0] ic,
                              input logic signed [CoordW-1:0] cx,
                              input logic signed [CoordW-1:0] cy,
                              input logic signed [CoordW-1:0] cz);
    int unsigned gap;
    in_valid_i <= 1'b1;
    kind_i     <= kind;
    index_a_i  <= ia;
    index_b_i  <= ib;
    index_c_i  <= ic;
    coord_x_i  <= cx;
    coord_y_i  <= cy;
    coord_z_i  <= cz;
    do @(posedge clk_i); while (in_stall_o);
    if (kind == KIND_WRITE && !is_written[ia]) begin
      is_written[ia] = 1'b1;
      written_idx.push_back(ia);
    end
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic write_vertex(input logic [IndexW-1:0] ia, input int cx, input int cy,
                              input int cz);
    send_request(KIND_WRITE, ia, IndexW'($urandom), IndexW'($urandom),
                 CoordW'(cx), CoordW'(cy), CoordW'(cz));
  endtask

  task automatic add_triangle(input logic [IndexW-1:0] ia, input logic [IndexW-1:0] ib,
                              input logic [IndexW-1:0] ic);
    send_request(KIND_TRI, ia, ib, ic, CoordW'($urandom), CoordW'($urandom),
                 CoordW'($urandom));
  endtask

  task automatic read_normal(input logic [IndexW-1:0] ia);
    send_request(KIND_READ, ia, IndexW'($urandom), IndexW'($urandom), CoordW'($urandom),
                 CoordW'($urandom), CoordW'($urandom));
  endtask

  initial begin
    int unsigned pick;
    logic [IndexW-1:0] a, b, c;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // coordinate and index extremes
    write_vertex(0, -8388608, -8388608, -8388608);
    write_vertex(4095, 8388607, 8388607, 8388607);
    write_vertex(1, 8388607, -8388608, 0);
    add_triangle(0, 4095, 1);
    read_normal(0);
    read_normal(4095);
    read_normal(1);
    // collinear and repeated corners add nothing
    write_vertex(2, 0, 0, 0);
    write_vertex(3, 65536, 65536, 65536);
    write_vertex(5, 131072, 131072, 131072);
    add_triangle(2, 3, 5);
    add_triangle(2, 2, 3);
    add_triangle(3, 5, 3);
    read_normal(2);
    // unused kind
    send_request(KIND_NONE, 7, 8, 9, 1, 2, 3);
    // freshly written vertex reads as zero
    write_vertex(6, 12345, -54321, 777);
    read_normal(6);
    // triangle then rewrite clears the sum
    add_triangle(6, 3, 1);
    read_normal(6);
    write_vertex(6, -1, 1, -1);
    read_normal(6);

    // axis-aligned triangle added with both windings
    write_vertex(10, 0, 0, 0);
    write_vertex(11, 65536, 0, 0);
    write_vertex(12, 0, 65536, 0);
    repeat (4) add_triangle(10, 11, 12);
    read_normal(10);
    repeat (6) add_triangle(10, 12, 11);
    read_normal(11);
    read_normal(12);

    // random traffic
    repeat (410) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        write_vertex(IndexW'($urandom), $urandom, $urandom, $urandom);
      end else if (pick < 75) begin
        a = written_idx[$urandom_range(0, written_idx.size() - 1)];
        b = written_idx[$urandom_range(0, written_idx.size() - 1)];
        c = written_idx[$urandom_range(0, written_idx.size() - 1)];
        add_triangle(a, b, c);
      end else if (pick < 95) begin
        read_normal(written_idx[$urandom_range(0, written_idx.size() - 1)]);
      end else begin
        send_request(KIND_NONE, IndexW'($urandom), IndexW'($urandom), IndexW'($urandom),
                     CoordW'($urandom), CoordW'($urandom), CoordW'($urandom));
      end
    end
    in_valid_i <= 1'b0;

    while (sb.pending_reads.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
    if (sb.errors == 0)
      $display("tb_vertex_normal_accumulator_top: clean");
    else
      $display("tb_vertex_normal_accumulator_top: errors");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/vna_pkg.sv
rtl/core/vna_unit.sv
rtl/core/vertex_normal_accumulator_top.sv
bench/tb_vertex_normal_accumulator_top.sv
